### src/cfdp_pkg.sv
// ----------------------------------------------------------------------------
// cfdp_pkg: shared definitions for the complex dot product block
// Default sizes, accumulator width, register map and the control group that
// drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cfdp_pkg;

  // Default sizes for the top level parameters.
  localparam int MAX_PAIRS_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Accumulator and result width, Q18.30 in 48 bits.
  localparam int ACC_W = 48;

  // Configuration port.
  localparam int PAIRS_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PAIRS_W;

  // Register map.
  localparam logic [CFG_IDX_W-1:0] REG_SYM_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIRS_USED = 1'd1;

  // Control group for the multiply-accumulate unit.
  typedef struct packed {
    logic vld;   // operands are valid this cycle
    logic seed;  // product replaces the sum instead of adding to it
    logic clr;   // clear the sum
  } mac_ctrl_t;

endpackage : cfdp_pkg

`default_nettype wire

### src/cfdp_ram.sv
// ----------------------------------------------------------------------------
// cfdp_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cfdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : cfdp_ram

`default_nettype wire

### src/cfdp_mac.sv
// ----------------------------------------------------------------------------
// cfdp_mac: shared complex-by-real multiply-accumulate unit
// Multiplies both parts of an operand by a real tap, registers the products
// and adds them into two saturating 48-bit sums on the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfdp_mac #(
  parameter int SAMPLE_BITS = cfdp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cfdp_pkg::mac_ctrl_t                ctrl,
  input  wire logic signed [SAMPLE_BITS:0]        a_re,
  input  wire logic signed [SAMPLE_BITS:0]        a_im,
  input  wire logic signed [SAMPLE_BITS-1:0]      b,
  output logic signed      [cfdp_pkg::ACC_W-1:0]  acc_re,
  output logic signed      [cfdp_pkg::ACC_W-1:0]  acc_im,
  output logic                                    busy
);

  import cfdp_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS + 1;
  localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;

  logic signed [PROD_W-1:0] prod_re_r, prod_re_nxt;
  logic signed [PROD_W-1:0] prod_im_r, prod_im_nxt;
  logic                     pv_r, ps_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_re_nxt;
  logic signed [ACC_W-1:0]  acc_im_r, acc_im_nxt;

  // Add a product to a base and clamp the result to the accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  base,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [SUM_W-1:0]  s;
    logic        [SUM_W-ACC_W:0] top;
    logic signed [ACC_W-1:0]  r;
    s   = SUM_W'(base) + SUM_W'(p);
    top = s[SUM_W-1:ACC_W-1];
    if ((&top) || (~|top)) begin
      r = s[ACC_W-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Multiply stage.
  assign prod_re_nxt = a_re * b;
  assign prod_im_nxt = a_im * b;

  // Accumulate stage; a seeded product starts the sum from zero.
  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (ctrl.clr) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
    end else if (pv_r) begin
      acc_re_nxt = sat_add(ps_r ? ACC_W'(0) : acc_re_r, prod_re_r);
      acc_im_nxt = sat_add(ps_r ? ACC_W'(0) : acc_im_r, prod_im_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r     <= 1'b0;
      ps_r     <= 1'b0;
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else begin
      pv_r     <= ctrl.vld;
      ps_r     <= ctrl.seed;
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
    end
  end

  // Product registers carry payload only.
  always_ff @(posedge clk) begin
    if (ctrl.vld) begin
      prod_re_r <= prod_re_nxt;
      prod_im_r <= prod_im_nxt;
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;
  assign busy   = pv_r;

endmodule : cfdp_mac

`default_nettype wire

### src/complex_fir_dot_product_sym_top.sv
// ----------------------------------------------------------------------------
// complex_fir_dot_product_sym_top: complex-by-real dot product, plain or folded
// Accumulates complex samples times real taps into saturating 48-bit sums,
// either directly or with the symmetric fold around a centre tap.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one sample, its tap and a last flag per beat;
//   the output channel carries one result beat per run, after the run's last
//   beat. Both channels use valid and stall. Write sym_mode and pairs_used
//   on the cfg port while the block is idle.
//   Plain mode takes one input beat per cycle up to a run's last beat; the
//   multiply-accumulate unit is pipelined two deep. After the last beat the
//   block stalls its input while the pipeline drains and the result is loaded.
//   Symmetric mode stores one beat per cycle in the sample and tap RAMs,
//   up to the run's last beat. After it the shared multiply-accumulate unit
//   folds one mirrored pair per cycle, with the input stalled meanwhile. A
//   run of the wrong length skips the fold and gives an error result.
//   The result sits in an output register; new input beats are taken while
//   it waits under stall, and only the next result waits for it to leave.
//   Reset clears the sums, the beat count, the config registers and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_fir_dot_product_sym_top #(
  parameter int MAX_PAIRS   = cfdp_pkg::MAX_PAIRS_DEF,
  parameter int SAMPLE_BITS = cfdp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_re,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_im,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_tap_value,
  input  wire logic                                in_last_item,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [cfdp_pkg::ACC_W-1:0]   out_sum_re,
  output logic signed      [cfdp_pkg::ACC_W-1:0]   out_sum_im,
  output logic                                     out_length_error,
  // Configuration port
  input  wire logic                                cfg_wr_en,
  input  wire logic [cfdp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cfdp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import cfdp_pkg::*;

  localparam int SB         = SAMPLE_BITS;
  localparam int SMP_DEPTH  = 2 * MAX_PAIRS + 1;
  localparam int TAP_DEPTH  = MAX_PAIRS + 1;
  localparam int COUNT_CEIL = 2 * MAX_PAIRS + 2;
  localparam int SAW        = $clog2(SMP_DEPTH);
  localparam int TAW        = $clog2(TAP_DEPTH);
  localparam int CNT_W      = $clog2(COUNT_CEIL + 1);
  localparam int CMP_W      = ((PAIRS_W > CNT_W) ? PAIRS_W : CNT_W) + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SEED  = 4'b0010,
    ST_FOLD  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    sym_mode_r;
  logic [PAIRS_W-1:0]      pairs_used_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [TAW-1:0]          n_r, n_nxt;
  logic [TAW-1:0]          k_r, k_nxt;
  logic [SAW-1:0]          hi_r, hi_nxt;
  logic                    err_r, err_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    rd_seed_r, rd_seed_nxt;
  logic                    op_vld_r, op_vld_nxt;
  logic                    op_seed_r, op_seed_nxt;
  logic signed [SB:0]      op_are_r, op_are_nxt;
  logic signed [SB:0]      op_aim_r, op_aim_nxt;
  logic signed [SB-1:0]    op_b_r, op_b_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [ACC_W-1:0] out_re_r, out_im_r;
  logic                    out_err_r;
  logic                    out_load;

  logic                    in_accept;
  logic [CNT_W-1:0]        total;
  logic [CMP_W-1:0]        pairs_ext, n_clamp, need_len;
  logic                    len_bad;

  logic                    smp_we, tap_we;
  logic [SAW-1:0]          lo_raddr;
  logic [TAW-1:0]          tap_raddr;
  logic [2*SB-1:0]         lo_rdata, hi_rdata;
  logic [SB-1:0]           tap_rdata;
  logic signed [SB-1:0]    lo_re, lo_im, hi_re, hi_im;

  mac_ctrl_t               mac_ctrl;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic                    mac_busy;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);

  // Run length check against 2N+1, with N clamped to the store size.
  assign total     = (count_r < CNT_W'(COUNT_CEIL)) ? count_r + CNT_W'(1) : count_r;
  assign pairs_ext = CMP_W'(pairs_used_r);
  assign n_clamp   = (pairs_ext > CMP_W'(MAX_PAIRS)) ? CMP_W'(MAX_PAIRS) : pairs_ext;
  assign need_len  = (n_clamp << 1) + CMP_W'(1);
  assign len_bad   = (CMP_W'(total) != need_len);

  // Sample and tap stores; the sample store is kept twice so a mirrored
  // pair can be read together.
  assign smp_we    = in_accept && (count_r < CNT_W'(SMP_DEPTH));
  assign tap_we    = in_accept && (count_r < CNT_W'(TAP_DEPTH));
  assign lo_raddr  = (state_r == ST_SEED) ? SAW'(n_r) : SAW'(k_r);
  assign tap_raddr = (state_r == ST_SEED) ? n_r : k_r;

  cfdp_ram #(.WIDTH(2 * SB), .DEPTH(SMP_DEPTH)) u_smp_lo (
    .clk   (clk),
    .we    (smp_we),
    .waddr (count_r[SAW-1:0]),
    .wdata ({in_sample_im, in_sample_re}),
    .raddr (lo_raddr),
    .rdata (lo_rdata)
  );

  cfdp_ram #(.WIDTH(2 * SB), .DEPTH(SMP_DEPTH)) u_smp_hi (
    .clk   (clk),
    .we    (smp_we),
    .waddr (count_r[SAW-1:0]),
    .wdata ({in_sample_im, in_sample_re}),
    .raddr (hi_r),
    .rdata (hi_rdata)
  );

  cfdp_ram #(.WIDTH(SB), .DEPTH(TAP_DEPTH)) u_tap (
    .clk   (clk),
    .we    (tap_we),
    .waddr (count_r[TAW-1:0]),
    .wdata (in_tap_value),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  assign lo_re = lo_rdata[SB-1:0];
  assign lo_im = lo_rdata[2*SB-1:SB];
  assign hi_re = hi_rdata[SB-1:0];
  assign hi_im = hi_rdata[2*SB-1:SB];

  // Sequencer and operand selection for the shared unit.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    hi_nxt      = hi_r;
    err_nxt     = err_r;
    rd_vld_nxt  = 1'b0;
    rd_seed_nxt = 1'b0;
    op_vld_nxt  = 1'b0;
    op_seed_nxt = 1'b0;
    op_are_nxt  = op_are_r;
    op_aim_nxt  = op_aim_r;
    op_b_nxt    = op_b_r;
    out_load    = 1'b0;

    // RAM data from the previous cycle: pre-add the mirrored pair.
    if (rd_vld_r) begin
      op_vld_nxt  = 1'b1;
      op_seed_nxt = rd_seed_r;
      op_are_nxt  = $signed({lo_re[SB-1], lo_re}) +
                    (rd_seed_r ? (SB+1)'(0) : $signed({hi_re[SB-1], hi_re}));
      op_aim_nxt  = $signed({lo_im[SB-1], lo_im}) +
                    (rd_seed_r ? (SB+1)'(0) : $signed({hi_im[SB-1], hi_im}));
      op_b_nxt    = tap_rdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          count_nxt = in_last_item ? CNT_W'(0) : total;
          if (!sym_mode_r) begin
            op_vld_nxt = 1'b1;
            op_are_nxt = {in_sample_re[SB-1], in_sample_re};
            op_aim_nxt = {in_sample_im[SB-1], in_sample_im};
            op_b_nxt   = in_tap_value;
          end
          if (in_last_item) begin
            if (!sym_mode_r) begin
              err_nxt   = 1'b0;
              state_nxt = ST_DRAIN;
            end else if (len_bad) begin
              err_nxt   = 1'b1;
              state_nxt = ST_DRAIN;
            end else begin
              err_nxt   = 1'b0;
              n_nxt     = n_clamp[TAW-1:0];
              state_nxt = ST_SEED;
            end
          end
        end
      end
      ST_SEED: begin
        // Centre sample times centre tap seeds the sum.
        rd_vld_nxt  = 1'b1;
        rd_seed_nxt = 1'b1;
        k_nxt       = '0;
        hi_nxt      = SAW'({n_r, 1'b0});
        state_nxt   = (n_r == '0) ? ST_DRAIN : ST_FOLD;
      end
      ST_FOLD: begin
        // One mirrored pair per cycle, low index upward.
        rd_vld_nxt = 1'b1;
        if (k_r == n_r - TAW'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt  = k_r + TAW'(1);
          hi_nxt = hi_r - SAW'(1);
        end
      end
      ST_DRAIN: begin
        // Wait for the pipeline to empty and the output register to free up.
        if (!rd_vld_r && !op_vld_r && !mac_busy && (!out_valid_r || !out_stall)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign mac_ctrl.vld  = op_vld_r;
  assign mac_ctrl.seed = op_seed_r;
  assign mac_ctrl.clr  = out_load;

  cfdp_mac #(.SAMPLE_BITS(SB)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .a_re   (op_are_r),
    .a_im   (op_aim_r),
    .b      (op_b_r),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .busy   (mac_busy)
  );

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rd_vld_r     <= 1'b0;
      rd_seed_r    <= 1'b0;
      op_vld_r     <= 1'b0;
      op_seed_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      sym_mode_r   <= 1'b0;
      pairs_used_r <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_seed_r   <= rd_seed_nxt;
      op_vld_r    <= op_vld_nxt;
      op_seed_r   <= op_seed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SYM_MODE:   sym_mode_r   <= cfg_data[0];
          REG_PAIRS_USED: pairs_used_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    hi_r     <= hi_nxt;
    err_r    <= err_nxt;
    op_are_r <= op_are_nxt;
    op_aim_r <= op_aim_nxt;
    op_b_r   <= op_b_nxt;
    if (out_load) begin
      out_re_r  <= err_r ? ACC_W'(0) : acc_re;
      out_im_r  <= err_r ? ACC_W'(0) : acc_im;
      out_err_r <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sum_re       = out_re_r;
  assign out_sum_im       = out_im_r;
  assign out_length_error = out_err_r;

endmodule : complex_fir_dot_product_sym_top

`default_nettype wire

### src/cfdp_checker.sv
// ----------------------------------------------------------------------------
// cfdp_checker: port-level checks for the complex dot product block
// Watches the channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cfdp_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              in_last_item,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [cfdp_pkg::ACC_W-1:0]        out_sum_re,
  input wire logic [cfdp_pkg::ACC_W-1:0]        out_sum_im,
  input wire logic                              out_length_error
);

  // A result beat held under stall stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // An error result carries zero sums.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_error |-> (out_sum_re == '0) && (out_sum_im == '0))
    else $error("error result with nonzero sums");

  // The input stalls right after the last beat of a run.
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_item |=> in_stall)
    else $error("input not stalled after last beat");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule : cfdp_checker

bind complex_fir_dot_product_sym_top cfdp_checker u_cfdp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_last_item     (in_last_item),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sum_re       (out_sum_re),
  .out_sum_im       (out_sum_im),
  .out_length_error (out_length_error)
);

`default_nettype wire
